// ----- rtl/chd_pkg.sv -----
// Shared types and constants for the chunked transfer decoder.
// No dependencies; chd_core, chd_outq and the top level import this package, as do the test files.
package chd_pkg;

  // Default width of the chunk size accumulator and payload counter.
  localparam int unsigned SIZE_BITS_DEF = 32;

  // Result queue depth. Keep a power of two so the pointers wrap freely.
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Characters the size line parser looks for.
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_TERM    = 2'd0,
    ST_NO_ZERO = 2'd1,
    ST_TRUNC   = 2'd2,
    ST_WIDE    = 2'd3
  } status_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    status_e    status;
  } result_t;

  // Results one accepted transfer produces: count 0..2, first entry in e0.
  typedef struct packed {
    logic [1:0] n;
    result_t    e0;
    result_t    e1;
  } push_t;

endpackage

// ----- rtl/chd_in_if.sv -----
// Input channel of the chunked transfer decoder: one encoded body byte per transfer.
// Depends on nothing.
interface chd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- rtl/chd_out_if.sv -----
// Result channel of the chunked transfer decoder: one payload byte or status per transfer.
// Depends on nothing.
interface chd_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] out_byte;
  logic [1:0] out_status;

  modport source (output valid, output out_kind, output out_byte, output out_status,
                  input ready);
  modport sink   (input valid, input out_kind, input out_byte, input out_status,
                  output ready);
endinterface

// ----- rtl/chd_core.sv -----
// Parser state and per-byte next-state logic of the chunked transfer decoder.
// Depends on chd_pkg.
module chd_core
  import chd_pkg::*;
#(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output push_t      push_o
);

  typedef enum logic [6:0] {
    PH_LEAD   = 7'b0000001,
    PH_DIGITS = 7'b0000010,
    PH_REST   = 7'b0000100,
    PH_DATA   = 7'b0001000,
    PH_CR     = 7'b0010000,
    PH_LF     = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [SIZE_BITS-1:0] acc_q, acc_d;
  logic [SIZE_BITS-1:0] left_q, left_d;
  logic                 seen_q, seen_d;
  logic                 wide_q, wide_d;

  logic                 taken;
  logic                 pay_v;
  logic                 hex_v;
  logic [3:0]           hex_n;
  status_e              st;
  result_t              pay_r, stat_r;

  // Hex digit decode: 0-9, a-f, A-F.
  always_comb begin
    hex_v = 1'b0;
    hex_n = 4'd0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      hex_v = 1'b1;
      hex_n = 4'(byte_i - 8'h30);
    end else if (byte_i >= 8'h61 && byte_i <= 8'h66) begin
      hex_v = 1'b1;
      hex_n = 4'(byte_i - 8'h57);
    end else if (byte_i >= 8'h41 && byte_i <= 8'h46) begin
      hex_v = 1'b1;
      hex_n = 4'(byte_i - 8'h37);
    end
  end

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    left_d  = left_q;
    seen_d  = seen_q;
    wide_d  = wide_q;
    taken   = 1'b0;
    pay_v   = 1'b0;

    // Payload bytes pass straight through; a finished body swallows bytes.
    if (phase_q == PH_DATA) begin
      pay_v  = 1'b1;
      left_d = left_q - SIZE_BITS'(1);
      if (left_q == SIZE_BITS'(1)) phase_d = PH_CR;
      taken  = 1'b1;
    end else if (phase_q == PH_DONE) begin
      taken = 1'b1;
    end

    // Optional CR then optional LF after a chunk; anything else falls through.
    if (!taken && phase_d == PH_CR) begin
      if (byte_i == CH_CR) begin
        phase_d = PH_LF;
        taken   = 1'b1;
      end else if (byte_i == CH_LF) begin
        phase_d = PH_LEAD;
        taken   = 1'b1;
      end else begin
        phase_d = PH_LEAD;
      end
    end
    if (!taken && phase_d == PH_LF) begin
      phase_d = PH_LEAD;
      if (byte_i == CH_LF) taken = 1'b1;
    end

    // Size line parsing.
    if (!taken) begin
      if (byte_i == CH_LF) begin
        if (seen_d && acc_d != '0) begin
          left_d  = acc_d;
          phase_d = PH_DATA;
        end else begin
          phase_d = PH_DONE;
        end
        acc_d  = '0;
        seen_d = 1'b0;
      end else if ((phase_d == PH_LEAD || phase_d == PH_DIGITS) && hex_v) begin
        if (acc_d[SIZE_BITS-1 -: 4] != 4'd0) begin
          wide_d  = 1'b1;
          phase_d = PH_DONE;
        end else begin
          acc_d   = {acc_d[SIZE_BITS-5:0], hex_n};
          seen_d  = 1'b1;
          phase_d = PH_DIGITS;
        end
      end else if (phase_d == PH_LEAD && (byte_i == CH_SPACE || byte_i == CH_TAB)) begin
        phase_d = PH_LEAD;
      end else begin
        phase_d = PH_REST;
      end
    end

    // Body end status, taken from the state after this byte.
    priority if (wide_d)         st = ST_WIDE;
    else if (phase_d == PH_DONE) st = ST_TERM;
    else if (phase_d == PH_DATA) st = ST_TRUNC;
    else                         st = ST_NO_ZERO;

    // The final byte returns the parser to its reset state.
    if (last_i) begin
      phase_d = PH_LEAD;
      acc_d   = '0;
      left_d  = '0;
      seen_d  = 1'b0;
      wide_d  = 1'b0;
    end
  end

  always_comb begin
    pay_r  = '{kind: KIND_DATA,   data: byte_i, status: ST_TERM};
    stat_r = '{kind: KIND_STATUS, data: 8'h00,  status: st};
    push_o.n  = accept_i ? (2'(pay_v) + 2'(last_i)) : 2'd0;
    push_o.e0 = pay_v ? pay_r : stat_r;
    push_o.e1 = stat_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      acc_q   <= '0;
      left_q  <= '0;
      seen_q  <= 1'b0;
      wide_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      seen_q  <= seen_d;
      wide_q  <= wide_d;
    end
  end

endmodule

// ----- rtl/chd_outq.sv -----
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on chd_pkg.
module chd_outq
  import chd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    space_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t head_o
);

  result_t              mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [OQ_CNT_W-1:0]  cnt_q, cnt_d;
  logic                 pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign head_o  = mem_q[rd_q];
  // Room for the worst case of two results from one transfer.
  assign space_o = (cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2));

  always_comb begin
    wr_d  = wr_q + OQ_PTR_W'(push_i.n);
    rd_d  = rd_q + OQ_PTR_W'(pop);
    cnt_d = cnt_q + OQ_CNT_W'(push_i.n) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.e0;
    if (push_i.n == 2'd2) mem_q[wr_q + OQ_PTR_W'(1)] <= push_i.e1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/chunked_transfer_decoder.sv -----
// Chunked transfer decoder, top level.
// Depends on chd_pkg, chd_in_if, chd_out_if, chd_core and chd_outq.
//
// Usage:
//   in_ch_i carries one byte of a chunk-encoded body per transfer, with
//   in_last set on the final byte of the body. out_ch_o carries results:
//   payload bytes (out_kind 0) in order, and after the final byte one status
//   result (out_kind 1) whose out_status tells how the body ended.
// Timing: each result is registered in the result queue and reaches out_ch_o
//   at the earliest in the cycle after the transfer that caused it.
// Throughput: one input byte per cycle while the queue has room. The parser
//   state updates in the cycle of the transfer, so consecutive bytes need no
//   gap. The final byte of a body may yield a payload byte and a status, two
//   results; the four-entry result queue drains one per cycle while out_ch_o is ready.
// Stalls: the queue keeps accepting input while results wait, and drops ready
//   on in_ch_i only when fewer than two entries are free.
// Reset: rst_ni clears the parser to the start of a size line and empties the
//   queue. After each final byte the parser returns to the same state by itself.
module chunked_transfer_decoder
  import chd_pkg::*;
#(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  chd_in_if.sink    in_ch_i,
  chd_out_if.source out_ch_o
);

  logic    accept;
  logic    space;
  push_t   push;
  result_t head;

  // Accept a transfer only when the queue can hold both possible results.
  assign in_ch_i.ready = space;
  assign accept        = in_ch_i.valid && space;

  chd_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_ch_i.in_byte),
    .last_i   (in_ch_i.in_last),
    .push_o   (push)
  );

  chd_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (out_ch_o.valid),
    .ready_i (out_ch_o.ready),
    .head_o  (head)
  );

  // Drive the result fields from the queue head.
  assign out_ch_o.out_kind   = head.kind;
  assign out_ch_o.out_byte   = head.data;
  assign out_ch_o.out_status = head.status;

endmodule

// ----- rtl/chd_checker.sv -----
// Port-level assertions for the chunked transfer decoder, bound to its top level.
// Depends on chunked_transfer_decoder.
module chd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_last_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_kind_i,
  input logic [7:0] out_byte_i,
  input logic [1:0] out_status_i
);

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) &&
    $stable(out_byte_i) && $stable(out_status_i))
    else $error("stalled result changed");

  // A status result carries no byte.
  a_status_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i |-> out_byte_i == 8'h00)
    else $error("status result with nonzero byte");

  // A payload result carries a zero status.
  a_data_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_kind_i |-> out_status_i == 2'd0)
    else $error("payload result with nonzero status");

  // The final byte of a body always leaves a result pending next cycle.
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> out_valid_i)
    else $error("no result after final byte");

endmodule

bind chunked_transfer_decoder chd_checker u_chd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch_i.valid),
  .in_ready_i   (in_ch_i.ready),
  .in_last_i    (in_ch_i.in_last),
  .out_valid_i  (out_ch_o.valid),
  .out_ready_i  (out_ch_o.ready),
  .out_kind_i   (out_ch_o.out_kind),
  .out_byte_i   (out_ch_o.out_byte),
  .out_status_i (out_ch_o.out_status)
);

// ----- tb/sv/chd_decode_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the chunked transfer decoder: decodes every accepted body
// byte on its own and compares each accepted result with the oldest one due.
// Depends on chd_pkg and the chd_in_if / chd_out_if channel interfaces.
module chd_decode_checker
  import chd_pkg::*;
#(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  chd_in_if           in_ch_i,
  chd_out_if          out_ch_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  localparam int unsigned REPORT_MAX = 10;

  typedef enum logic [2:0] {
    P_BLANK,
    P_DIGITS,
    P_SKIP,
    P_DATA,
    P_CR,
    P_LF,
    P_DONE
  } line_phase_e;

  line_phase_e          phase;
  logic [SIZE_BITS-1:0] size_acc;
  logic [SIZE_BITS-1:0] payload_left;
  logic                 digit_seen;
  logic                 too_wide;
  result_t              due_q[$];
  int unsigned          fail_cnt;

  function automatic void clear_parser();
    phase        = P_BLANK;
    size_acc     = '0;
    payload_left = '0;
    digit_seen   = 1'b0;
    too_wide     = 1'b0;
  endfunction

  // Shift one hex digit into the size, or stop decoding if it would not fit.
  function automatic void take_digit(logic [3:0] nib);
    if (size_acc[SIZE_BITS-1 -: 4] != 4'd0) begin
      too_wide = 1'b1;
      phase    = P_DONE;
    end else begin
      size_acc   = {size_acc[SIZE_BITS-5:0], nib};
      digit_seen = 1'b1;
      phase      = P_DIGITS;
    end
  endfunction

  function automatic void decode_byte(logic [7:0] c, logic last);
    int      v;
    logic    taken;
    result_t r;
    status_e st;
    v = -1;
    if (c >= 8'h30 && c <= 8'h39) v = int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) v = int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) v = int'(c - 8'h41) + 10;
    taken = 1'b0;
    if (phase == P_DATA) begin
      r.kind   = KIND_DATA;
      r.data   = c;
      r.status = ST_TERM;
      due_q.insert(due_q.size(), r);
      payload_left = payload_left - SIZE_BITS'(1);
      if (payload_left == '0) phase = P_CR;
      taken = 1'b1;
    end else if (phase == P_DONE) begin
      taken = 1'b1;
    end
    if (!taken && phase == P_CR) begin
      if (c == CH_CR) begin
        phase = P_LF;
        taken = 1'b1;
      end else if (c == CH_LF) begin
        phase = P_BLANK;
        taken = 1'b1;
      end else begin
        phase = P_BLANK;
      end
    end
    if (!taken && phase == P_LF) begin
      phase = P_BLANK;
      if (c == CH_LF) taken = 1'b1;
    end
    if (!taken) begin
      if (c == CH_LF) begin
        if (digit_seen && size_acc != '0) begin
          payload_left = size_acc;
          phase        = P_DATA;
        end else begin
          phase = P_DONE;
        end
        size_acc   = '0;
        digit_seen = 1'b0;
      end else if (phase == P_BLANK) begin
        if (c != CH_SPACE && c != CH_TAB) begin
          if (v >= 0) take_digit(v[3:0]);
          else phase = P_SKIP;
        end
      end else if (phase == P_DIGITS) begin
        if (v >= 0) take_digit(v[3:0]);
        else phase = P_SKIP;
      end else begin
        phase = P_SKIP;
      end
    end
    if (last) begin
      if (too_wide) st = ST_WIDE;
      else if (phase == P_DONE) st = ST_TERM;
      else if (phase == P_DATA && payload_left != '0) st = ST_TRUNC;
      else st = ST_NO_ZERO;
      r.kind   = KIND_STATUS;
      r.data   = 8'h00;
      r.status = st;
      due_q.insert(due_q.size(), r);
      clear_parser();
    end
  endfunction

  function automatic void log_fail(string why, result_t exp, result_t got);
    fail_cnt++;
    if (fail_cnt <= REPORT_MAX)
      $display({"%0t chd_decode_checker: %s: exp kind=%0d byte=%02h status=%0d,",
                " got kind=%0d byte=%02h status=%0d"},
               $time, why, exp.kind, exp.data, exp.status,
               got.kind, got.data, got.status);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t exp;
    if (!rst_ni) begin
      clear_parser();
      due_q.delete();
      fail_cnt = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      // Check results first: a result never leaves in the cycle of its own transfer.
      if (out_ch_i.valid && out_ch_i.ready) begin
        got.kind   = kind_e'(out_ch_i.out_kind);
        got.data   = out_ch_i.out_byte;
        got.status = status_e'(out_ch_i.out_status);
        if (due_q.size() == 0) begin
          log_fail("result with nothing due", '0, got);
        end else begin
          exp = due_q.pop_front();
          if (got.kind !== exp.kind) log_fail("out_kind mismatch", exp, got);
          else if (got.data !== exp.data) log_fail("out_byte mismatch", exp, got);
          else if (got.status !== exp.status) log_fail("out_status mismatch", exp, got);
        end
      end
      if (in_ch_i.valid && in_ch_i.ready) decode_byte(in_ch_i.in_byte, in_ch_i.in_last);
      fail_cnt_o <= fail_cnt;
      pending_o  <= due_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_chunked_transfer_decoder.sv -----
`timescale 1ns / 100ps
// Testbench top for the chunked transfer decoder: builds encoded bodies, drives
// them with random gaps and stalls, and reports the verdict of chd_decode_checker.
// Depends on chd_pkg, chd_in_if, chd_out_if, chunked_transfer_decoder, chd_decode_checker.
module tb_chunked_transfer_decoder
  import chd_pkg::*;
();

  localparam int unsigned RESET_CYC    = 3;
  localparam int unsigned BODY_BYTES   = 1400;
  localparam int unsigned SQUEEZE_AT   = 500;   // input transfers before the long hold-off
  localparam int unsigned SQUEEZE_CYC  = 300;
  localparam int unsigned DRAIN_CYC    = 10;
  localparam int unsigned WATCHDOG_CYC = 4000;

  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } body_byte_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned xfers_in = 0;
  int unsigned quiet_cyc = 0;
  body_byte_t  body_q[$];

  chd_in_if  in_ch ();
  chd_out_if out_ch ();

  chunked_transfer_decoder i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  chd_decode_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch_i    (in_ch),
    .out_ch_i   (out_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Body builder: the functions below build encoded bodies in body_q.
  // ---------------------------------------------------------------------------

  function automatic void put(logic [7:0] b);
    body_q.insert(body_q.size(), '{data: b, last: 1'b0});
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  // Flag the final byte of the body that is being built.
  function automatic void close_body();
    body_q[body_q.size()-1].last = 1'b1;
  endfunction

  // Hex digit with random letter case.
  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return CH_ZERO + nib;
    if ($urandom_range(0, 1) != 0) return CH_LOWER_A + nib - 8'd10;
    return CH_UPPER_A + nib - 8'd10;
  endfunction

  // Size line: optional blanks, optional leading zeros, the digits, maybe an
  // extension, then CR LF or a bare LF.
  function automatic void put_size_line(logic [31:0] n);
    int unsigned ndig;
    int unsigned sel;
    ndig = 1;
    while (ndig < 8 && (n >> (4 * ndig)) != 0) ndig++;
    repeat ($urandom_range(0, 2)) put(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put(CH_ZERO);
    for (int i = ndig - 1; i >= 0; i--) put(hex_char(n[4*i +: 4]));
    sel = $urandom_range(0, 9);
    if (sel < 2) put_text(";ext=1");
    else if (sel == 2) put_text(" ;q");
    if ($urandom_range(0, 4) != 0) put(CH_CR);
    put(CH_LF);
  endfunction

  // One chunk: size line, payload of random bytes, then the usual CR LF or a
  // damaged trailer (CR only, LF only, nothing).
  function automatic void put_chunk();
    int unsigned len;
    int unsigned sel;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    put_size_line(len);
    repeat (len) put(8'($urandom));
    sel = $urandom_range(0, 19);
    if (sel != 17 && sel != 19) put(CH_CR);
    if (sel != 18 && sel != 19) put(CH_LF);
  endfunction

  function automatic void gen_body();
    int unsigned start;
    int unsigned form;
    int unsigned cut;
    int unsigned sel;
    start = body_q.size();
    form  = $urandom_range(0, 99);
    if (form < 80) begin
      // Chunked body; the last form leaves out the zero chunk.
      repeat ($urandom_range(1, 4)) put_chunk();
      if (form < 75) begin
        sel = $urandom_range(0, 5);
        if (sel == 0) put_text("\r\n");          // digitless line also ends it
        else if (sel == 1) put_text(";only\n");
        else put_size_line(0);
        sel = $urandom_range(0, 9);
        if (sel < 6) put_text("\r\n");
        else if (sel < 8) repeat ($urandom_range(1, 4)) put(8'($urandom));
      end
      // Cut a share of the bodies at a random byte.
      if (form >= 65 && form < 75) begin
        cut = $urandom_range(start + 1, body_q.size());
        while (body_q.size() > cut) void'(body_q.pop_back());
      end
    end else if (form < 88) begin
      if ($urandom_range(0, 1) != 0) begin
        // More digits than the size accumulator holds.
        put(hex_char(4'($urandom_range(1, 15))));
        repeat ($urandom_range(8, 11)) put(hex_char(4'($urandom)));
        repeat ($urandom_range(0, 4)) put(8'($urandom));
      end else begin
        // Huge size that fits, then only a few payload bytes.
        put_size_line({4'($urandom_range(1, 15)), 28'($urandom)});
        repeat ($urandom_range(1, 6)) put(8'($urandom));
      end
    end else begin
      // Noise.
      if ($urandom_range(0, 2) == 0) put(CH_SEMI);
      repeat ($urandom_range(1, 8)) put(8'($urandom));
    end
    close_body();
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: directed bodies, then random ones; reset, drive, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    in_ch.in_last <= 1'b0;

    // Leading blanks, an extension, payload extremes, a missing trailer, and a
    // body that ends on an unfinished size line.
    put_text(" \t2;x\n");
    put(8'h00);
    put(8'hFF);
    put_text("0");
    close_body();
    // A 0x prefix ends the digits at the x: size zero ends decoding.
    put_text("0x5\n");
    close_body();
    // Nine digits overflow a 32-bit size.
    put_text("fffffffff");
    close_body();
    // Body ends inside the payload: one data byte and a status in one transfer.
    put_text("B\r\n");
    put(8'h5A);
    close_body();
    while (body_q.size() < BODY_BYTES) gen_body();

    repeat (RESET_CYC) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned idx = 0; idx < body_q.size(); idx++) begin
      // Keep every fourth block of items free of gaps.
      gap = ((idx / 128) % 4 == 1) ? 0 : idle_len();
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_ch.valid   <= 1'b1;
      in_ch.in_byte <= body_q[idx].data;
      in_ch.in_last <= body_q[idx].last;
      @(posedge clk_i);
      // Hold the transfer until the block takes it.
      while (!in_ch.ready) @(posedge clk_i);
      xfers_in++;
    end
    in_ch.valid <= 1'b0;

    // Drain: let the checker count the final transfer, wait for every result
    // due, then a few cycles for strays.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb_chunked_transfer_decoder: done, clean");
    end else begin
      $display("tb_chunked_transfer_decoder: done, errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls with calm stretches, and one long hold-off while
  // the sender keeps offering, so the result queue fills and input stalls.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    int unsigned hold;
    bit          steady;
    bit          squeezed;
    steady   = 1'b0;
    squeezed = 1'b0;
    out_ch.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!squeezed && xfers_in >= SQUEEZE_AT) begin
        out_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYC) @(posedge clk_i);
        squeezed = 1'b1;
      end else begin
        if ($urandom_range(0, 15) == 0) steady = !steady;
        stall = steady ? 0 : idle_len();
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_ch.ready <= 1'b1;
        hold = $urandom_range(1, 12);
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cyc <= 0;
      else quiet_cyc <= quiet_cyc + 1;
      if (quiet_cyc >= WATCHDOG_CYC) begin
        $display("tb_chunked_transfer_decoder: done, errors");
        $finish;
      end
    end
  end

endmodule
